// File: hdl/snoop_response_scoreboard_assert.svh
// ------------------------------------------------------------------------
// Snoop response scoreboard assertion macros
// Shared concurrent assertion forms used at the end of the top level.
// ------------------------------------------------------------------------
`ifndef SNOOP_RESPONSE_SCOREBOARD_ASSERT_SVH
`define SNOOP_RESPONSE_SCOREBOARD_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SRSB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("snoop response scoreboard: implication check failed");

// Latency check of the consequent against the antecedent.
`define SRSB_ASSERT_LAT2(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
        else $error("snoop response scoreboard: latency check failed");

`endif

// File: hdl/srsb_pkg.sv
// ------------------------------------------------------------------------
// Snoop response scoreboard package
// Widths, codes and the control structures shared by the scoreboard files.
// ------------------------------------------------------------------------
`default_nettype none

package srsb_pkg;

    // Default sizes of the scoreboard.
    localparam int SLOTS_DEF     = 16;
    localparam int ADDR_BITS_DEF = 32;
    localparam int TAG_BITS_DEF  = 8;

    // Fixed field widths.
    localparam int ID_W   = 4;
    localparam int OP_W   = 2;
    localparam int KIND_W = 2;
    localparam int RK_W   = 3;
    localparam int RESP_W = 2;

    // Command codes.
    localparam logic [OP_W-1:0] OP_SNOOP  = 2'd0;
    localparam logic [OP_W-1:0] OP_MARK   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Transaction classes.
    localparam logic [KIND_W-1:0] KIND_REQUEST     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITEBACK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_WRITE_PURGE = 2'd2;

    // Request kinds.
    localparam logic [RK_W-1:0] RK_READ_SH      = 3'd0;
    localparam logic [RK_W-1:0] RK_READ_CURRENT = 3'd2;
    localparam logic [RK_W-1:0] RK_READ_UC      = 3'd4;
    localparam logic [RK_W-1:0] RK_WRITE_UC     = 3'd5;
    localparam logic [RK_W-1:0] RK_SWAP_UC      = 3'd6;

    // Snoop answers.
    localparam logic [RESP_W-1:0] RESP_EXCL   = 2'd0;
    localparam logic [RESP_W-1:0] RESP_SHARED = 2'd1;
    localparam logic [RESP_W-1:0] RESP_STALL  = 2'd2;

    // Update request from the top level to the slot store.
    typedef struct packed {
        logic              ins;
        logic              mark;
        logic              rem;
        logic [KIND_W-1:0] cls;
        logic [RK_W-1:0]   rk;
    } t_slot_cmd;

    // Lookup and fill status from the slot store.
    typedef struct packed {
        logic              hit;
        logic              full;
        logic [KIND_W-1:0] cls;
        logic [RK_W-1:0]   rk;
    } t_slot_stat;

endpackage

`default_nettype wire

// File: hdl/srsb_slots.sv
// ------------------------------------------------------------------------
// Scoreboard slot store
// Pending transaction slots in flip-flops with parallel address and tag
// compares, first-match selection, insert, mark and compacting removal.
// ------------------------------------------------------------------------
`default_nettype none

module srsb_slots #(
    parameter int SLOTS     = srsb_pkg::SLOTS_DEF,
    parameter int ADDR_BITS = srsb_pkg::ADDR_BITS_DEF,
    parameter int TAG_BITS  = srsb_pkg::TAG_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire srsb_pkg::t_slot_cmd   i_cmd,
    input  wire logic [ADDR_BITS-1:0]  i_addr,
    input  wire logic [TAG_BITS-1:0]   i_tag,
    output srsb_pkg::t_slot_stat       o_stat
);

    localparam int FILL_W = $clog2(SLOTS + 1);
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Slot contents; only slots below the fill count are ever read.
    logic [ADDR_BITS-1:0]       r_addr  [SLOTS];
    logic [srsb_pkg::KIND_W-1:0] r_cls  [SLOTS];
    logic [srsb_pkg::RK_W-1:0]   r_rk   [SLOTS];
    logic [TAG_BITS-1:0]        r_ident [SLOTS];
    logic [FILL_W-1:0]          r_fill;
    logic [FILL_W-1:0]          n_fill;

    logic [SLOTS-1:0]            w_amatch;
    logic [SLOTS-1:0]            w_tmatch;
    logic [SLOTS-1:0]            w_afirst;
    logic [SLOTS-1:0]            w_tfirst;
    logic                        w_full;
    logic                        w_do_ins;
    logic                        w_do_rem;
    logic [FILL_W-1:0]           w_last;
    logic [IDX_W-1:0]            w_last_idx;
    logic [srsb_pkg::KIND_W-1:0] w_sel_cls;
    logic [srsb_pkg::RK_W-1:0]   w_sel_rk;

    // Parallel compares against every valid slot.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_amatch[i] = (FILL_W'(i) < r_fill) && (r_addr[i] == i_addr);
            w_tmatch[i] = (FILL_W'(i) < r_fill) && (r_ident[i] == i_tag);
        end
    end

    // Isolate the lowest matching slot of each compare.
    assign w_afirst = w_amatch & (~w_amatch + SLOTS'(1));
    assign w_tfirst = w_tmatch & (~w_tmatch + SLOTS'(1));

    // Class and request kind of the first address hit.
    always_comb begin
        w_sel_cls = '0;
        w_sel_rk  = '0;
        for (int i = 0; i < SLOTS; i++) begin
            w_sel_cls = w_sel_cls | (r_cls[i] & {srsb_pkg::KIND_W{w_afirst[i]}});
            w_sel_rk  = w_sel_rk | (r_rk[i] & {srsb_pkg::RK_W{w_afirst[i]}});
        end
    end

    // Fill control and the last valid slot used to close a gap.
    assign w_full     = (r_fill == FILL_W'(SLOTS));
    assign w_do_ins   = i_cmd.ins && !w_full;
    assign w_do_rem   = i_cmd.rem && (|w_tmatch);
    assign w_last     = r_fill - FILL_W'(1);
    assign w_last_idx = w_last[IDX_W-1:0];

    always_comb begin
        n_fill = r_fill;
        if (w_do_ins) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (w_do_rem) begin
            n_fill = w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    // Slot updates: insert at the fill count, mark or replace the first tag hit.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (w_do_ins && (FILL_W'(i) == r_fill)) begin
                r_addr[i]  <= i_addr;
                r_cls[i]   <= i_cmd.cls;
                r_rk[i]    <= i_cmd.rk;
                r_ident[i] <= i_tag;
            end else if (i_cmd.mark && w_tfirst[i]) begin
                r_cls[i] <= srsb_pkg::KIND_WRITEBACK;
            end else if (i_cmd.rem && w_tfirst[i]) begin
                r_addr[i]  <= r_addr[w_last_idx];
                r_cls[i]   <= r_cls[w_last_idx];
                r_rk[i]    <= r_rk[w_last_idx];
                r_ident[i] <= r_ident[w_last_idx];
            end
        end
    end

    // Lookup status covers the slots that were valid before this command.
    assign o_stat.hit  = |w_amatch;
    assign o_stat.full = w_full;
    assign o_stat.cls  = w_sel_cls;
    assign o_stat.rk   = w_sel_rk;

endmodule

`default_nettype wire

// File: hdl/srsb_decide.sv
// ------------------------------------------------------------------------
// Snoop answer decision
// Chooses exclusive, shared or stall from the snooped request and the
// first scoreboard entry that holds its address.
// ------------------------------------------------------------------------
`default_nettype none

module srsb_decide (
    input  wire logic                        i_own,
    input  wire logic [srsb_pkg::KIND_W-1:0] i_kind,
    input  wire logic [srsb_pkg::RK_W-1:0]   i_req_kind,
    input  wire srsb_pkg::t_slot_stat        i_stat,
    output logic [srsb_pkg::RESP_W-1:0]      o_response
);

    // Priority of the answer rules, highest first.
    always_comb begin
        if (i_own || !i_stat.hit) begin
            o_response = srsb_pkg::RESP_EXCL;
        end else if ((i_stat.cls == srsb_pkg::KIND_REQUEST)
                     && (i_stat.rk == srsb_pkg::RK_READ_CURRENT)) begin
            o_response = srsb_pkg::RESP_EXCL;
        end else if ((i_kind == srsb_pkg::KIND_REQUEST)
                     && (i_req_kind == srsb_pkg::RK_READ_SH)
                     && (i_stat.cls == srsb_pkg::KIND_REQUEST)
                     && (i_stat.rk == srsb_pkg::RK_READ_SH)) begin
            o_response = srsb_pkg::RESP_SHARED;
        end else if (i_kind == srsb_pkg::KIND_WRITE_PURGE) begin
            o_response = srsb_pkg::RESP_EXCL;
        end else begin
            o_response = srsb_pkg::RESP_STALL;
        end
    end

endmodule

`default_nettype wire

// File: hdl/snoop_response_scoreboard.sv
// ------------------------------------------------------------------------
// Snoop response scoreboard
// Answers snooped bus requests from a scoreboard of the agent's own
// pending transactions and maintains that scoreboard.
// ------------------------------------------------------------------------
// The block takes one command in every clock cycle: busy stays low, so a
// command is transferred at each edge at which start is high. Its result
// passes through the command register and then the result register, and
// is on the result ports for exactly one cycle, marked by o_result_valid;
// the receiver cannot stall it and must take it in that cycle. Results
// leave in command order. The rate is set by the combinational pass from
// the command register through the parallel compare of all scoreboard
// slots into the result register. The scoreboard sits in flip-flops and
// needs no clearing pass after reset. The own master number is written
// through the configuration channel, which is always ready; the user must
// write it while no command is in flight, as the block does not enforce it.
`default_nettype none
`include "snoop_response_scoreboard_assert.svh"

module snoop_response_scoreboard #(
    parameter int SLOTS     = srsb_pkg::SLOTS_DEF,
    parameter int ADDR_BITS = srsb_pkg::ADDR_BITS_DEF,
    parameter int TAG_BITS  = srsb_pkg::TAG_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // Configuration channel
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [srsb_pkg::ID_W-1:0]   i_cfg_data,
    // Command channel
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [srsb_pkg::OP_W-1:0]   i_op,
    input  wire logic [srsb_pkg::ID_W-1:0]   i_src_id,
    input  wire logic [srsb_pkg::KIND_W-1:0] i_kind,
    input  wire logic [srsb_pkg::RK_W-1:0]   i_req_kind,
    input  wire logic [ADDR_BITS-1:0]        i_line_addr,
    input  wire logic [TAG_BITS-1:0]         i_tag,
    // Result channel
    output logic                             o_result_valid,
    output logic [srsb_pkg::RESP_W-1:0]      o_response,
    output logic                             o_hit,
    output logic                             o_overflow
);

    // Configuration register.
    logic [srsb_pkg::ID_W-1:0] r_own_id;

    // Command register.
    logic                        r_in_valid;
    logic [srsb_pkg::OP_W-1:0]   r_op;
    logic [srsb_pkg::ID_W-1:0]   r_src_id;
    logic [srsb_pkg::KIND_W-1:0] r_kind;
    logic [srsb_pkg::RK_W-1:0]   r_req_kind;
    logic [ADDR_BITS-1:0]        r_line_addr;
    logic [TAG_BITS-1:0]         r_tag;

    // Result register.
    logic                        r_out_valid;
    logic [srsb_pkg::RESP_W-1:0] r_response;
    logic                        r_hit;
    logic                        r_overflow;

    logic                        w_accept;
    logic                        w_snoop;
    logic                        w_own;
    logic                        w_uncached;
    logic                        w_ins_req;
    logic [srsb_pkg::RESP_W-1:0] w_response;
    srsb_pkg::t_slot_cmd         w_cmd;
    srsb_pkg::t_slot_stat        w_stat;
    logic                        w_sh_out;
    logic                        w_ovf_out;
    logic                        w_excl_out;

    // Both channels are always open.
    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;
    assign w_accept    = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_own_id <= i_cfg_data;
        end
    end

    // Capture each transferred command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= i_op;
            r_src_id    <= i_src_id;
            r_kind      <= i_kind;
            r_req_kind  <= i_req_kind;
            r_line_addr <= i_line_addr;
            r_tag       <= i_tag;
        end
    end

    // Uncached request kinds never enter the scoreboard.
    always_comb begin
        case (r_req_kind) inside
            srsb_pkg::RK_READ_UC, srsb_pkg::RK_WRITE_UC, srsb_pkg::RK_SWAP_UC: begin
                w_uncached = 1'b1;
            end
            default: begin
                w_uncached = 1'b0;
            end
        endcase
    end

    // Command decode into a slot store update.
    assign w_snoop   = r_in_valid && (r_op == srsb_pkg::OP_SNOOP);
    assign w_own     = (r_src_id == r_own_id);
    assign w_ins_req = w_snoop && w_own && (r_kind == srsb_pkg::KIND_REQUEST) && !w_uncached;

    assign w_cmd.ins  = w_ins_req;
    assign w_cmd.mark = r_in_valid && (r_op == srsb_pkg::OP_MARK);
    assign w_cmd.rem  = r_in_valid && (r_op == srsb_pkg::OP_REMOVE);
    assign w_cmd.cls  = r_kind;
    assign w_cmd.rk   = r_req_kind;

    srsb_slots #(
        .SLOTS     (SLOTS),
        .ADDR_BITS (ADDR_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_addr  (r_line_addr),
        .i_tag   (r_tag),
        .o_stat  (w_stat)
    );

    srsb_decide u_decide (
        .i_own      (w_own),
        .i_kind     (r_kind),
        .i_req_kind (r_req_kind),
        .i_stat     (w_stat),
        .o_response (w_response)
    );

    // Result register; a freshly inserted own request always hits itself.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_response <= w_snoop ? w_response : srsb_pkg::RESP_EXCL;
            r_hit      <= w_snoop && (w_stat.hit || (w_ins_req && !w_stat.full));
            r_overflow <= w_ins_req && w_stat.full;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_response     = r_response;
    assign o_hit          = r_hit;
    assign o_overflow     = r_overflow;

    // Result conditions watched by the checks below.
    assign w_sh_out   = o_result_valid && (o_response == srsb_pkg::RESP_SHARED);
    assign w_ovf_out  = o_result_valid && o_overflow;
    assign w_excl_out = (o_response == srsb_pkg::RESP_EXCL);

    // Checks on latency and on the consistency of result fields.
    `SRSB_ASSERT_LAT2(a_result_latency, i_clk, i_rst_n, w_accept, o_result_valid)
    `SRSB_ASSERT_IMPL(a_shared_needs_hit, i_clk, i_rst_n, w_sh_out, o_hit)
    `SRSB_ASSERT_IMPL(a_overflow_excl, i_clk, i_rst_n, w_ovf_out, w_excl_out && $past(w_stat.full))

endmodule

`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// ------------------------------------------------------------------------
// Snoop response scoreboard testbench
// Sends directed and random commands with random gaps. Each transfer is
// fed to a scoreboard object that predicts the snoop answer. Each result
// is checked, field by field, against the oldest prediction.
// ------------------------------------------------------------------------
module tb;

    localparam int SLOTS       = srsb_pkg::SLOTS_DEF;
    localparam int ADDR_W      = srsb_pkg::ADDR_BITS_DEF;
    localparam int TAG_W       = srsb_pkg::TAG_BITS_DEF;
    localparam int ID_W        = srsb_pkg::ID_W;
    localparam int OP_W        = srsb_pkg::OP_W;
    localparam int KIND_W      = srsb_pkg::KIND_W;
    localparam int RK_W        = srsb_pkg::RK_W;
    localparam int RESP_W      = srsb_pkg::RESP_W;
    localparam int LATENCY     = 2;
    localparam int CYCLE_LIMIT = 200000;

    // Codes that the package leaves unnamed.
    localparam logic [OP_W-1:0]   OP_SPARE      = 2'd3;
    localparam logic [KIND_W-1:0] KIND_OTHER    = 2'd3;
    localparam logic [RK_W-1:0]   RK_READ_OWN   = 3'd1;
    localparam logic [RK_W-1:0]   RK_UPGRADE    = 3'd3;
    localparam logic [RK_W-1:0]   RK_OTHER      = 3'd7;

    // Shapes of the random blocks.
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   src_id;
        logic [KIND_W-1:0] kind;
        logic [RK_W-1:0]   req_kind;
        logic [ADDR_W-1:0] line_addr;
        logic [TAG_W-1:0]  tag;
    } t_cmd;

    typedef struct packed {
        logic [RESP_W-1:0] response;
        logic              hit;
        logic              overflow;
    } t_answer;

    // Predicts snoop answers from its own copy of the pending table.
    class answer_scoreboard;
        logic [ADDR_W-1:0] slot_addr [SLOTS];
        logic [KIND_W-1:0] slot_cls  [SLOTS];
        logic [RK_W-1:0]   slot_rk   [SLOTS];
        logic [TAG_W-1:0]  slot_tag  [SLOTS];
        int                fill   = 0;
        logic [ID_W-1:0]   own_id = '0;
        t_answer           pending [$];
        int                errors = 0;

        task report(input string what);
            errors++;
            $display("MISMATCH %s", what);
        endtask

        // Lowest valid slot holding the address, or -1.
        function int find_addr(input logic [ADDR_W-1:0] a);
            int idx;
            idx = -1;
            for (int i = fill - 1; i >= 0; i--)
                if (slot_addr[i] == a) idx = i;
            return idx;
        endfunction

        // Lowest valid slot holding the tag, or -1.
        function int find_tag(input logic [TAG_W-1:0] t);
            int idx;
            idx = -1;
            for (int i = fill - 1; i >= 0; i--)
                if (slot_tag[i] == t) idx = i;
            return idx;
        endfunction

        // Apply one transferred command and queue the answer it causes.
        function void note_command(input t_cmd c);
            t_answer a;
            int      s;
            bit      own;
            a = '0;
            a.response = srsb_pkg::RESP_EXCL;
            case (c.op)
                srsb_pkg::OP_SNOOP: begin
                    own = (c.src_id == own_id);
                    // The agent's own coherent requests enter the table first.
                    if (own && c.kind == srsb_pkg::KIND_REQUEST &&
                        c.req_kind != srsb_pkg::RK_READ_UC &&
                        c.req_kind != srsb_pkg::RK_WRITE_UC &&
                        c.req_kind != srsb_pkg::RK_SWAP_UC) begin
                        if (fill >= SLOTS) begin
                            a.overflow = 1'b1;
                        end else begin
                            slot_addr[fill] = c.line_addr;
                            slot_cls[fill]  = c.kind;
                            slot_rk[fill]   = c.req_kind;
                            slot_tag[fill]  = c.tag;
                            fill++;
                        end
                    end
                    s = find_addr(c.line_addr);
                    a.hit = (s >= 0);
                    if (!own && s >= 0) begin
                        if (slot_cls[s] == srsb_pkg::KIND_REQUEST &&
                            slot_rk[s] == srsb_pkg::RK_READ_CURRENT)
                            a.response = srsb_pkg::RESP_EXCL;
                        else if (c.kind == srsb_pkg::KIND_REQUEST &&
                                 c.req_kind == srsb_pkg::RK_READ_SH &&
                                 slot_cls[s] == srsb_pkg::KIND_REQUEST &&
                                 slot_rk[s] == srsb_pkg::RK_READ_SH)
                            a.response = srsb_pkg::RESP_SHARED;
                        else if (c.kind == srsb_pkg::KIND_WRITE_PURGE)
                            a.response = srsb_pkg::RESP_EXCL;
                        else
                            a.response = srsb_pkg::RESP_STALL;
                    end
                end
                srsb_pkg::OP_MARK: begin
                    s = find_tag(c.tag);
                    if (s >= 0) slot_cls[s] = srsb_pkg::KIND_WRITEBACK;
                end
                srsb_pkg::OP_REMOVE: begin
                    // The last valid slot fills the hole.
                    s = find_tag(c.tag);
                    if (s >= 0) begin
                        slot_addr[s] = slot_addr[fill-1];
                        slot_cls[s]  = slot_cls[fill-1];
                        slot_rk[s]   = slot_rk[fill-1];
                        slot_tag[s]  = slot_tag[fill-1];
                        fill--;
                    end
                end
                default: ;
            endcase
            pending.push_back(a);
        endfunction

        // Compare one result with the oldest prediction.
        task check_answer(input t_answer got);
            t_answer want;
            if (pending.size() == 0) begin
                report("result with no command waiting");
            end else begin
                want = pending.pop_front();
                if (got.response !== want.response)
                    report($sformatf("response got %0d want %0d", got.response,
                                     want.response));
                if (got.hit !== want.hit)
                    report($sformatf("hit got %0d want %0d", got.hit, want.hit));
                if (got.overflow !== want.overflow)
                    report($sformatf("overflow got %0d want %0d", got.overflow,
                                     want.overflow));
            end
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [ID_W-1:0]   i_cfg_data = '0;
    logic              start = 1'b0;
    logic              busy;
    logic [OP_W-1:0]   i_op = '0;
    logic [ID_W-1:0]   i_src_id = '0;
    logic [KIND_W-1:0] i_kind = '0;
    logic [RK_W-1:0]   i_req_kind = '0;
    logic [ADDR_W-1:0] i_line_addr = '0;
    logic [TAG_W-1:0]  i_tag = '0;
    logic              o_result_valid;
    logic [RESP_W-1:0] o_response;
    logic              o_hit;
    logic              o_overflow;

    answer_scoreboard  sb;
    logic [ADDR_W-1:0] addr_pool [8];
    logic [TAG_W-1:0]  tag_pool  [8];
    int                cycles = 0;

    snoop_response_scoreboard DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_src_id       (i_src_id),
        .i_kind         (i_kind),
        .i_req_kind     (i_req_kind),
        .i_line_addr    (i_line_addr),
        .i_tag          (i_tag),
        .o_result_valid (o_result_valid),
        .o_response     (o_response),
        .o_hit          (o_hit),
        .o_overflow     (o_overflow)
    );

    always #4 i_clk = ~i_clk;

    // Watch the command, result and configuration channels at the rising edge and feed the scoreboard.
    always @(posedge i_clk) begin
        t_answer got;
        t_cmd    seen;
        if (i_rst_n) begin
            if (o_result_valid) begin
                got.response = o_response;
                got.hit      = o_hit;
                got.overflow = o_overflow;
                sb.check_answer(got);
            end
            if (start && !busy) begin
                seen.op        = i_op;
                seen.src_id    = i_src_id;
                seen.kind      = i_kind;
                seen.req_kind  = i_req_kind;
                seen.line_addr = i_line_addr;
                seen.tag       = i_tag;
                sb.note_command(seen);
            end
            if (i_cfg_valid && o_cfg_ready) sb.own_id = i_cfg_data;
        end
    end

    // Give up on a run that hangs.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    function automatic t_cmd mk(input logic [OP_W-1:0] op, input logic [ID_W-1:0] src,
                                input logic [KIND_W-1:0] kind, input logic [RK_W-1:0] rk,
                                input logic [ADDR_W-1:0] addr, input logic [TAG_W-1:0] tag);
        t_cmd c;
        c.op        = op;
        c.src_id    = src;
        c.kind      = kind;
        c.req_kind  = rk;
        c.line_addr = addr;
        c.tag       = tag;
        return c;
    endfunction

    // Present one command and hold it until it is transferred.
    task automatic send_cmd(input t_cmd c);
        @(negedge i_clk);
        start       <= 1'b1;
        i_op        <= c.op;
        i_src_id    <= c.src_id;
        i_kind      <= c.kind;
        i_req_kind  <= c.req_kind;
        i_line_addr <= c.line_addr;
        i_tag       <= c.tag;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_off(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    // Stop sending until every predicted answer has arrived.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_own_id(input logic [ID_W-1:0] v);
        wait_drained();
        repeat (LATENCY + 2) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap(input bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random command, biased towards live addresses and tags so that
    // snoops hit and removals find their entries.
    function automatic t_cmd random_cmd(input int mode);
        t_cmd c;
        int   r;
        c.op        = srsb_pkg::OP_SNOOP;
        c.src_id    = ID_W'($urandom_range(0, 15));
        c.kind      = KIND_W'($urandom_range(0, 3));
        c.req_kind  = RK_W'($urandom_range(0, 7));
        c.line_addr = ($urandom_range(0, 99) < 75) ? addr_pool[$urandom_range(0, 7)]
                                                   : ADDR_W'($urandom);
        c.tag       = ($urandom_range(0, 99) < 60) ? tag_pool[$urandom_range(0, 7)]
                                                   : TAG_W'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 8) c.op = srsb_pkg::OP_REMOVE;
                else if (r < 12) c.op = srsb_pkg::OP_MARK;
                if ($urandom_range(0, 99) < 85) c.src_id = sb.own_id;
                if ($urandom_range(0, 99) < 90) c.kind = srsb_pkg::KIND_REQUEST;
                if ($urandom_range(0, 99) < 60)
                    c.req_kind = $urandom_range(0, 1) ? srsb_pkg::RK_READ_SH
                                                      : srsb_pkg::RK_READ_CURRENT;
            end
            MODE_DRAIN: begin
                if (r < 50) c.op = srsb_pkg::OP_REMOVE;
                else if (r < 65) c.op = srsb_pkg::OP_MARK;
            end
            default: begin
                if (r < 20) c.op = srsb_pkg::OP_REMOVE;
                else if (r < 35) c.op = srsb_pkg::OP_MARK;
                else if (r < 40) c.op = OP_SPARE;
                if ($urandom_range(0, 99) < 35) c.src_id = sb.own_id;
            end
        endcase
        if (sb.fill > 0) begin
            if ((c.op == srsb_pkg::OP_MARK || c.op == srsb_pkg::OP_REMOVE) &&
                $urandom_range(0, 99) < 80)
                c.tag = sb.slot_tag[$urandom_range(0, sb.fill - 1)];
            if (c.op == srsb_pkg::OP_SNOOP && $urandom_range(0, 1))
                c.line_addr = sb.slot_addr[$urandom_range(0, sb.fill - 1)];
        end
        return c;
    endfunction

    localparam logic [ID_W-1:0]   OWN   = 4'd5;
    localparam logic [ID_W-1:0]   OTHER = 4'd3;
    localparam logic [ADDR_W-1:0] ADDR_A = 32'h0000_0000;
    localparam logic [ADDR_W-1:0] ADDR_B = 32'hFFFF_FFFF;
    localparam logic [ADDR_W-1:0] ADDR_C = 32'h1234_5678;

    localparam logic [OP_W-1:0]   SNP  = srsb_pkg::OP_SNOOP;
    localparam logic [OP_W-1:0]   MRK  = srsb_pkg::OP_MARK;
    localparam logic [OP_W-1:0]   RMV  = srsb_pkg::OP_REMOVE;
    localparam logic [KIND_W-1:0] REQ  = srsb_pkg::KIND_REQUEST;
    localparam logic [KIND_W-1:0] WB   = srsb_pkg::KIND_WRITEBACK;
    localparam logic [KIND_W-1:0] WP   = srsb_pkg::KIND_WRITE_PURGE;
    localparam logic [RK_W-1:0]   RSH  = srsb_pkg::RK_READ_SH;
    localparam logic [RK_W-1:0]   RCUR = srsb_pkg::RK_READ_CURRENT;

    initial begin
        logic [ID_W-1:0] phase_id [4];
        int              mode;
        bit              quiet;

        sb = new;
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        tag_pool[0]  = '0;
        tag_pool[1]  = '1;
        for (int i = 2; i < 8; i++) begin
            addr_pool[i] = ADDR_W'($urandom);
            tag_pool[i]  = TAG_W'($urandom_range(0, 255));
        end

        // Synchronous reset, held low from the start.
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: every answer, marking, removal and their misses.
        write_own_id(OWN);
        send_cmd(mk(OP_SPARE, OTHER, REQ, RSH, ADDR_C, 8'h00));
        send_cmd(mk(SNP, OTHER, REQ, RSH, ADDR_A, 8'h00));
        send_cmd(mk(SNP, OWN, REQ, RSH, ADDR_A, 8'h00));
        send_cmd(mk(SNP, OTHER, REQ, RSH, ADDR_A, 8'h00));
        send_cmd(mk(SNP, OTHER, KIND_OTHER, RK_OTHER, ADDR_A, 8'h00));
        send_cmd(mk(SNP, OTHER, WP, RK_OTHER, ADDR_A, 8'h00));
        send_cmd(mk(SNP, OWN, REQ, RCUR, ADDR_B, 8'hFF));
        send_cmd(mk(SNP, OTHER, REQ, RK_READ_OWN, ADDR_B, 8'h00));
        send_cmd(mk(SNP, OWN, REQ, srsb_pkg::RK_READ_UC, ADDR_C, 8'h33));
        send_cmd(mk(SNP, OWN, WB, RSH, ADDR_A, 8'h44));
        send_cmd(mk(MRK, OTHER, REQ, RSH, ADDR_C, 8'h00));
        send_cmd(mk(SNP, 4'd15, REQ, RSH, ADDR_A, 8'h00));
        send_cmd(mk(MRK, OTHER, REQ, RSH, ADDR_C, 8'h55));
        send_cmd(mk(RMV, OTHER, REQ, RSH, ADDR_C, 8'h00));
        send_cmd(mk(SNP, 4'd0, REQ, RK_UPGRADE, ADDR_A, 8'h00));
        send_cmd(mk(SNP, OTHER, REQ, RK_UPGRADE, ADDR_B, 8'h00));
        send_cmd(mk(RMV, OTHER, REQ, RSH, ADDR_C, 8'h55));
        // Duplicate tags: removal takes the lowest slot.
        send_cmd(mk(SNP, OWN, REQ, RK_UPGRADE, ADDR_C, 8'h12));
        send_cmd(mk(SNP, OWN, REQ, RK_READ_OWN, ADDR_C, 8'h12));
        send_cmd(mk(RMV, OTHER, REQ, RSH, ADDR_C, 8'h12));
        send_cmd(mk(SNP, OTHER, REQ, srsb_pkg::RK_WRITE_UC, ADDR_C, 8'h00));
        send_cmd(mk(SNP, OTHER, REQ, srsb_pkg::RK_SWAP_UC, ADDR_B, 8'hFF));

        // Random part: four settings of the master number, five blocks each.
        phase_id[0] = 4'd15;
        phase_id[1] = 4'd0;
        phase_id[2] = ID_W'($urandom_range(1, 14));
        phase_id[3] = ID_W'($urandom_range(0, 15));
        for (int p = 0; p < 4; p++) begin
            write_own_id(phase_id[p]);
            for (int b = 0; b < 5; b++) begin
                mode  = (b == 0) ? MODE_FILL : $urandom_range(0, 2);
                quiet = ($urandom_range(0, 3) == 0);
                for (int n = 0; n < 25; n++) begin
                    send_cmd(random_cmd(mode));
                    hold_off(pick_gap(quiet));
                end
                // Let the pipeline run dry once in the middle of a phase.
                if (p == 1 && b == 2) wait_drained();
            end
        end

        // Drain, then wait for stray results.
        wait_drained();
        repeat (LATENCY + 6) @(negedge i_clk);
        if (sb.pending.size() != 0)
            sb.report($sformatf("%0d answers never arrived", sb.pending.size()));
        if (sb.errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
